@@ rtl/ppe_pkg.sv @@
// ----------------------------------------------------------------------------
// ppe_pkg: shared types and helpers for the predator-prey Euler stepper
// Sequencer states, register indexes, field widths and saturation helpers.
// ----------------------------------------------------------------------------
package ppe_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int RUN_LEN_W  = 21;
  localparam int STEP_NUM_W = 20;
  localparam int TIME_W     = 48;
  localparam int POP_W      = 32;
  localparam int CHANGE_W   = 41;
  localparam int XY_W       = 48;
  localparam int HALF_XY_W  = 24;
  localparam int PART_W     = 56;
  localparam int TERM_W     = 52;
  localparam int DELTA_W    = 54;

  localparam logic [CFG_IDX_W-1:0] REG_PREY_START          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREDATOR_START      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PREY_GROWTH         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PREDATOR_DEATH      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PREY_FEEDS_PREDATOR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PREDATOR_EATS_PREY  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP           = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_LENGTH          = 3'd7;

  localparam logic [CFG_DATA_W-1:0] TIME_STEP_RESET  = 32'h1000_0000;
  localparam logic [RUN_LEN_W-1:0]  RUN_LENGTH_RESET = 21'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RATE_G,
    S_RATE_D,
    S_RATE_E,
    S_RATE_F,
    S_RATE_END,
    S_MUL_XY,
    S_MUL_GX,
    S_MUL_DY,
    S_MUL_EH,
    S_MUL_EL,
    S_MUL_FH,
    S_MUL_FL,
    S_MUL_T,
    S_FINISH
  } state_t;

  // Q4.28 times Q4.28 product back to Q4.28, saturated
  function automatic logic [POP_W-1:0] sat_rate(input logic [63:0] p);
    if (|p[63:60]) begin
      sat_rate = '1;
    end else begin
      sat_rate = p[59:28];
    end
  endfunction

  // floor((hi * 2^24 + lo) / 2^28) without the full 80-bit sum
  function automatic logic [TERM_W-1:0] join_parts(input logic [PART_W-1:0] hi,
                                                   input logic [PART_W-1:0] lo);
    logic [PART_W:0] low_sum;
    logic [TERM_W:0] total;
    low_sum = {29'd0, hi[3:0], 24'd0} + {1'b0, lo};
    total   = {1'b0, hi[PART_W-1:4]} + {24'd0, low_sum[PART_W:28]};
    join_parts = total[TERM_W-1:0];
  endfunction

  function automatic logic [POP_W-1:0] clamp_pop(input logic signed [DELTA_W-1:0] v);
    if (v[DELTA_W-1]) begin
      clamp_pop = '0;
    end else if (|v[DELTA_W-2:POP_W]) begin
      clamp_pop = '1;
    end else begin
      clamp_pop = v[POP_W-1:0];
    end
  endfunction

  function automatic logic signed [CHANGE_W-1:0] sat_change(
      input logic signed [DELTA_W-1:0] v);
    if ((&v[DELTA_W-1:CHANGE_W-1]) || !(|v[DELTA_W-1:CHANGE_W-1])) begin
      sat_change = v[CHANGE_W-1:0];
    end else if (v[DELTA_W-1]) begin
      sat_change = {1'b1, {(CHANGE_W-1){1'b0}}};
    end else begin
      sat_change = {1'b0, {(CHANGE_W-1){1'b1}}};
    end
  endfunction

endpackage

@@ rtl/ppe_if.sv @@
// ----------------------------------------------------------------------------
// ppe_if: item channels of the predator-prey Euler stepper
// Tick channel (restart flag) and row channel (one integration result).
// ----------------------------------------------------------------------------
interface ppe_tick_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface ppe_row_if
  import ppe_pkg::*;
;
  logic                        valid;
  logic                        ready;
  logic [STEP_NUM_W-1:0]       step_number;
  logic [TIME_W-1:0]           time_value;
  logic [POP_W-1:0]            prey_level;
  logic [POP_W-1:0]            predator_level;
  logic signed [CHANGE_W-1:0]  prey_change;
  logic signed [CHANGE_W-1:0]  predator_change;
  logic                        last_row;

  modport source (output valid, output step_number, output time_value,
                  output prey_level, output predator_level, output prey_change,
                  output predator_change, output last_row, input ready);
  modport sink   (input valid, input step_number, input time_value,
                  input prey_level, input predator_level, input prey_change,
                  input predator_change, input last_row, output ready);
endinterface

@@ rtl/predator_prey_euler_step.sv @@
// ----------------------------------------------------------------------------
// predator_prey_euler_step: fixed-point forward-Euler Lotka-Volterra stepper
// One 32x32 multiplier, sequenced over rate scaling and one integration step.
// ----------------------------------------------------------------------------
// Usage:
//   Write the eight registers through cfg_write/cfg_index/cfg_data while the
//   block is idle. Each item on the tick channel makes one step: restart=1
//   reloads the start populations, scales the four rates by the time step and
//   zeroes the step index before stepping; restart=0 advances the running
//   simulation. Each step sends one item on the row channel. After the row
//   marked last_row, ticks without restart are taken and dropped.
// Sequence:
//   An advance tick runs S_MUL_XY through S_MUL_T, then S_FINISH; a restart
//   tick first runs S_RATE_G through S_RATE_END and goes on at S_MUL_GX. A
//   dropped tick leaves the sequencer idle. Every product goes through the
//   single shared multiplier, one per cycle: 8 per step plus 4 for rate
//   scaling. Tick ready is high only while the sequencer is idle.
// Reset and stall:
//   Reset clears the run, the populations, the scaled rates and the row
//   valid flag, and loads register defaults (time step 1.0, run_length 1).
//   The finished row waits in an output register; a new tick is taken while
//   it waits, and the next row holds in the last sequencer state until the
//   receiver takes the previous one.
// ----------------------------------------------------------------------------
module predator_prey_euler_step
  import ppe_pkg::*;
#(
  parameter int STEP_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  ppe_tick_if.sink              tick,
  ppe_row_if.source             row
);

  localparam int CMP_W = (STEP_BITS + 1 > RUN_LEN_W) ? STEP_BITS + 1 : RUN_LEN_W;
  localparam logic [CMP_W-1:0] RUN_CAP = CMP_W'(1) << STEP_BITS;

  // configuration registers
  logic [POP_W-1:0]      prey_start;
  logic [POP_W-1:0]      predator_start;
  logic [POP_W-1:0]      prey_growth;
  logic [POP_W-1:0]      predator_death;
  logic [POP_W-1:0]      prey_feeds_predator;
  logic [POP_W-1:0]      predator_eats_prey;
  logic [POP_W-1:0]      time_step;
  logic [RUN_LEN_W-1:0]  run_length;

  // run state
  state_t                state, state_next;
  logic [POP_W-1:0]      prey_now;
  logic [POP_W-1:0]      predator_now;
  logic [STEP_BITS-1:0]  step_counter;
  logic                  run_active;
  logic [POP_W-1:0]      scaled_rates [4];

  // shared multiplier and partial results
  logic [31:0]           mul_a, mul_b;
  logic [63:0]           mul_p;
  logic [XY_W-1:0]       xy;
  logic [35:0]           term_a, term_c;
  logic [PART_W-1:0]     part_hi;
  logic [TERM_W-1:0]     term_b, term_f;

  // row register
  logic                  row_valid;
  logic [STEP_NUM_W-1:0] row_step;
  logic [TIME_W-1:0]     row_time;
  logic [POP_W-1:0]      row_prey;
  logic [POP_W-1:0]      row_predator;
  logic signed [CHANGE_W-1:0] row_prey_change;
  logic signed [CHANGE_W-1:0] row_predator_change;
  logic                  row_last;

  logic                  tick_ready;
  logic                  tick_fire;
  logic                  row_load;

  // finish-step arithmetic
  logic signed [DELTA_W-1:0] d_prey, d_pred;
  logic [POP_W-1:0]      prey_new, predator_new;
  logic [TIME_W-1:0]     time_now;
  logic [CMP_W-1:0]      run_limit;
  logic [CMP_W-1:0]      step_plus;
  logic                  last_now;

  assign tick_fire = tick.valid && tick_ready;

  // ---------------- configuration write port ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      prey_start          <= '0;
      predator_start      <= '0;
      prey_growth         <= '0;
      predator_death      <= '0;
      prey_feeds_predator <= '0;
      predator_eats_prey  <= '0;
      time_step           <= TIME_STEP_RESET;
      run_length          <= RUN_LENGTH_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PREY_START:          prey_start          <= cfg_data;
        REG_PREDATOR_START:      predator_start      <= cfg_data;
        REG_PREY_GROWTH:         prey_growth         <= cfg_data;
        REG_PREDATOR_DEATH:      predator_death      <= cfg_data;
        REG_PREY_FEEDS_PREDATOR: prey_feeds_predator <= cfg_data;
        REG_PREDATOR_EATS_PREY:  predator_eats_prey  <= cfg_data;
        REG_TIME_STEP:           time_step           <= cfg_data;
        REG_RUN_LENGTH:          run_length          <= cfg_data[RUN_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- sequencer: next state ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (tick_fire) begin
          if (tick.restart) begin
            state_next = S_RATE_G;
          end else if (run_active) begin
            state_next = S_MUL_XY;
          end
        end
      end
      S_RATE_G:   state_next = S_RATE_D;
      S_RATE_D:   state_next = S_RATE_E;
      S_RATE_E:   state_next = S_RATE_F;
      S_RATE_F:   state_next = S_RATE_END;
      S_RATE_END: state_next = S_MUL_GX;
      S_MUL_XY:   state_next = S_MUL_GX;
      S_MUL_GX:   state_next = S_MUL_DY;
      S_MUL_DY:   state_next = S_MUL_EH;
      S_MUL_EH:   state_next = S_MUL_EL;
      S_MUL_EL:   state_next = S_MUL_FH;
      S_MUL_FH:   state_next = S_MUL_FL;
      S_MUL_FL:   state_next = S_MUL_T;
      S_MUL_T:    state_next = S_FINISH;
      S_FINISH: begin
        if (row_load) begin
          state_next = S_IDLE;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // ---------------- sequencer: outputs and multiplier operands ----------------
  always_comb begin
    tick_ready = 1'b0;
    row_load   = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      S_IDLE:     tick_ready = 1'b1;
      S_RATE_G:   begin mul_a = prey_growth;         mul_b = time_step;    end
      S_RATE_D:   begin mul_a = predator_death;      mul_b = time_step;    end
      S_RATE_E:   begin mul_a = predator_eats_prey;  mul_b = time_step;    end
      S_RATE_F:   begin mul_a = prey_feeds_predator; mul_b = time_step;    end
      S_RATE_END, S_MUL_XY: begin
        mul_a = prey_now;
        mul_b = predator_now;
      end
      S_MUL_GX:   begin mul_a = scaled_rates[0];     mul_b = prey_now;     end
      S_MUL_DY:   begin mul_a = scaled_rates[1];     mul_b = predator_now; end
      S_MUL_EH: begin
        mul_a = scaled_rates[2];
        mul_b = {8'd0, xy[XY_W-1:HALF_XY_W]};
      end
      S_MUL_EL: begin
        mul_a = scaled_rates[2];
        mul_b = {8'd0, xy[HALF_XY_W-1:0]};
      end
      S_MUL_FH: begin
        mul_a = scaled_rates[3];
        mul_b = {8'd0, xy[XY_W-1:HALF_XY_W]};
      end
      S_MUL_FL: begin
        mul_a = scaled_rates[3];
        mul_b = {8'd0, xy[HALF_XY_W-1:0]};
      end
      S_MUL_T: begin
        mul_a = 32'(step_counter);
        mul_b = time_step;
      end
      S_FINISH: begin
        // keep the time product in place while the row register is busy
        mul_a    = 32'(step_counter);
        mul_b    = time_step;
        row_load = !row_valid || row.ready;
      end
      default: ;
    endcase
  end

  // ---------------- finish-step arithmetic ----------------
  always_comb begin
    d_prey       = DELTA_W'(signed'({1'b0, term_a}))
                 - DELTA_W'(signed'({1'b0, term_b}));
    d_pred       = DELTA_W'(signed'({1'b0, term_f}))
                 - DELTA_W'(signed'({1'b0, term_c}));
    prey_new     = clamp_pop(DELTA_W'(signed'({1'b0, prey_now})) + d_prey);
    predator_new = clamp_pop(DELTA_W'(signed'({1'b0, predator_now})) + d_pred);
    time_now     = (|mul_p[63:TIME_W]) ? '1 : mul_p[TIME_W-1:0];

    // zero run length means one step; cap at the counter range
    run_limit = CMP_W'(run_length);
    if (run_limit == '0) begin
      run_limit = CMP_W'(1);
    end else if (run_limit > RUN_CAP) begin
      run_limit = RUN_CAP;
    end
    step_plus = CMP_W'(step_counter) + CMP_W'(1);
    last_now  = (step_plus >= run_limit);
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      prey_now     <= '0;
      predator_now <= '0;
      step_counter <= '0;
      run_active   <= 1'b0;
      row_valid    <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        scaled_rates[i] <= '0;
      end
    end else begin
      state <= state_next;

      if (row_load) begin
        row_valid <= 1'b1;
      end else if (row.ready) begin
        row_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (tick_fire && tick.restart) begin
            prey_now     <= prey_start;
            predator_now <= predator_start;
            step_counter <= '0;
            run_active   <= 1'b1;
          end
        end
        S_RATE_D:   scaled_rates[0] <= sat_rate(mul_p);
        S_RATE_E:   scaled_rates[1] <= sat_rate(mul_p);
        S_RATE_F:   scaled_rates[2] <= sat_rate(mul_p);
        S_RATE_END: scaled_rates[3] <= sat_rate(mul_p);
        S_FINISH: begin
          if (row_load) begin
            prey_now     <= prey_new;
            predator_now <= predator_new;
            if (last_now) begin
              run_active <= 1'b0;
            end else begin
              step_counter <= step_counter + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
    case (state)
      S_MUL_GX: xy      <= mul_p[63:16];
      S_MUL_DY: term_a  <= mul_p[63:28];
      S_MUL_EH: term_c  <= mul_p[63:28];
      S_MUL_EL: part_hi <= mul_p[PART_W-1:0];
      S_MUL_FH: term_b  <= join_parts(part_hi, mul_p[PART_W-1:0]);
      S_MUL_FL: part_hi <= mul_p[PART_W-1:0];
      S_MUL_T:  term_f  <= join_parts(part_hi, mul_p[PART_W-1:0]);
      default: ;
    endcase
    if (row_load) begin
      row_step            <= STEP_NUM_W'(step_counter);
      row_time            <= time_now;
      row_prey            <= prey_new;
      row_predator        <= predator_new;
      row_prey_change     <= sat_change(d_prey);
      row_predator_change <= sat_change(d_pred);
      row_last            <= last_now;
    end
  end

  // ---------------- channel outputs ----------------
  assign tick.ready          = tick_ready;
  assign row.valid           = row_valid;
  assign row.step_number     = row_step;
  assign row.time_value      = row_time;
  assign row.prey_level      = row_prey;
  assign row.predator_level  = row_predator;
  assign row.prey_change     = row_prey_change;
  assign row.predator_change = row_predator_change;
  assign row.last_row        = row_last;

  // ---------------- assertions ----------------
  // the sequencer only runs with a live simulation
  a_busy_needs_run: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> run_active)
    else $error("sequencer busy without an active run");

  // a tick with no run and no restart is dropped and the sequencer stays idle
  a_drop_idle_tick: assert property (@(posedge clk) disable iff (rst)
    tick_fire && !tick.restart && !run_active |=> state == S_IDLE && !row_load)
    else $error("idle tick started a step");

  // the last row ends the run
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    row_load && last_now |=> !run_active)
    else $error("run still active after last row");

  // rows inside a run count up by one
  a_step_advance: assert property (@(posedge clk) disable iff (rst)
    row_load && !last_now |=> step_counter == STEP_BITS'($past(step_counter) + 1'b1))
    else $error("step index did not advance");

endmodule

@@ tb/ppe_row_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppe_row_checker: row predictor and scoreboard for the Euler stepper
// Follows register writes and accepted ticks, predicts each row in fixed
// point and compares the rows taken from the block in order.
// ----------------------------------------------------------------------------
module ppe_row_checker
  import ppe_pkg::*;
#(
  parameter int STEP_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  ppe_tick_if                   tick,
  ppe_row_if                    row,
  output int                    fail_count,
  output int                    rows_pending
);

  localparam int                NUM_REGS   = 8;
  localparam logic [63:0]       POP_MAX    = 64'hFFFF_FFFF;
  localparam logic signed [63:0] LEVEL_MAX = 64'sh0000_0000_FFFF_FFFF;
  localparam logic signed [63:0] CHANGE_HI = (64'sd1 <<< (CHANGE_W - 1)) - 64'sd1;
  localparam logic signed [63:0] CHANGE_LO = -(64'sd1 <<< (CHANGE_W - 1));
  localparam logic [63:0]       TIME_MAX   = (64'd1 << TIME_W) - 64'd1;
  localparam logic [63:0]       COUNT_MASK = (64'd1 << STEP_BITS) - 64'd1;
  localparam logic [63:0]       RUN_CAP    = 64'd1 << STEP_BITS;
  localparam logic [31:0]       RUN_MASK   = (32'd1 << RUN_LEN_W) - 32'd1;

  typedef struct packed {
    logic [STEP_NUM_W-1:0] step_number;
    logic [TIME_W-1:0]     time_value;
    logic [POP_W-1:0]      prey_level;
    logic [POP_W-1:0]      predator_level;
    logic [CHANGE_W-1:0]   prey_change;
    logic [CHANGE_W-1:0]   predator_change;
    logic                  last_row;
  } row_t;

  logic [CFG_DATA_W-1:0] regs [NUM_REGS];
  logic [POP_W-1:0]      prey;
  logic [POP_W-1:0]      predator;
  logic [63:0]           step_idx;
  logic                  run_on;
  logic [POP_W-1:0]      growth_dt;
  logic [POP_W-1:0]      death_dt;
  logic [POP_W-1:0]      eats_dt;
  logic [POP_W-1:0]      feeds_dt;
  row_t                  expected_rows [$];
  row_t                  want;

  // rate times step size back to Q4.28, saturated to 32 bits
  function automatic logic [POP_W-1:0] rate_times_dt(input logic [31:0] rate,
                                                     input logic [31:0] dt);
    logic [63:0] p;
    p = ({32'd0, rate} * {32'd0, dt}) >> 28;
    return (p > POP_MAX) ? POP_MAX[POP_W-1:0] : p[POP_W-1:0];
  endfunction

  // floor(r * v / 2^28), exact
  function automatic logic signed [63:0] q28_term(input logic [31:0] r,
                                                  input logic [47:0] v);
    logic [79:0] p;
    p = {48'd0, r} * {32'd0, v};
    return signed'({12'd0, p[79:28]});
  endfunction

  function automatic logic [POP_W-1:0] clamp_level(input logic signed [63:0] v);
    if (v < 64'sd0) begin
      return '0;
    end else if (v > LEVEL_MAX) begin
      return '1;
    end
    return v[POP_W-1:0];
  endfunction

  function automatic logic [CHANGE_W-1:0] sat_delta(input logic signed [63:0] v);
    if (v > CHANGE_HI) begin
      return CHANGE_HI[CHANGE_W-1:0];
    end else if (v < CHANGE_LO) begin
      return CHANGE_LO[CHANGE_W-1:0];
    end
    return v[CHANGE_W-1:0];
  endfunction

  task automatic check_field(input string field_name, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s expected %0h got %0h", $time, field_name, exp_v, got_v);
      fail_count++;
    end
  endtask

  task automatic predict_tick(input logic restart);
    logic [47:0]        xy;
    logic signed [63:0] d_prey;
    logic signed [63:0] d_pred;
    logic [63:0]        t;
    logic [63:0]        limit;
    logic               final_step;
    row_t               r;
    if (restart) begin
      prey      = regs[REG_PREY_START];
      predator  = regs[REG_PREDATOR_START];
      growth_dt = rate_times_dt(regs[REG_PREY_GROWTH], regs[REG_TIME_STEP]);
      death_dt  = rate_times_dt(regs[REG_PREDATOR_DEATH], regs[REG_TIME_STEP]);
      eats_dt   = rate_times_dt(regs[REG_PREDATOR_EATS_PREY], regs[REG_TIME_STEP]);
      feeds_dt  = rate_times_dt(regs[REG_PREY_FEEDS_PREDATOR], regs[REG_TIME_STEP]);
      step_idx  = '0;
      run_on    = 1'b1;
    end
    if (run_on) begin
      // both changes come from the populations before the step
      xy     = 48'(({32'd0, prey} * {32'd0, predator}) >> 16);
      d_prey = q28_term(growth_dt, {16'd0, prey}) - q28_term(eats_dt, xy);
      d_pred = q28_term(feeds_dt, xy) - q28_term(death_dt, {16'd0, predator});
      prey     = clamp_level(signed'({32'd0, prey}) + d_prey);
      predator = clamp_level(signed'({32'd0, predator}) + d_pred);

      t = step_idx * {32'd0, regs[REG_TIME_STEP]};
      if (t > TIME_MAX) begin
        t = TIME_MAX;
      end
      limit = {32'd0, regs[REG_RUN_LENGTH]};
      if (limit == 64'd0) begin
        limit = 64'd1;
      end else if (limit > RUN_CAP) begin
        limit = RUN_CAP;
      end
      final_step = (step_idx + 64'd1 >= limit);

      r.step_number     = step_idx[STEP_NUM_W-1:0];
      r.time_value      = t[TIME_W-1:0];
      r.prey_level      = prey;
      r.predator_level  = predator;
      r.prey_change     = sat_delta(d_prey);
      r.predator_change = sat_delta(d_pred);
      r.last_row        = final_step;
      expected_rows.push_back(r);

      if (final_step) begin
        run_on = 1'b0;
      end else begin
        step_idx = (step_idx + 64'd1) & COUNT_MASK;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] = '0;
      end
      regs[REG_TIME_STEP]  = TIME_STEP_RESET;
      regs[REG_RUN_LENGTH] = 32'(RUN_LENGTH_RESET);
      prey         = '0;
      predator     = '0;
      step_idx     = '0;
      run_on       = 1'b0;
      growth_dt    = '0;
      death_dt     = '0;
      eats_dt      = '0;
      feeds_dt     = '0;
      expected_rows.delete();
      fail_count   = 0;
      rows_pending = 0;
    end else begin
      if (cfg_write) begin
        regs[cfg_index] = (cfg_index == REG_RUN_LENGTH) ? (cfg_data & RUN_MASK) : cfg_data;
      end
      if (row.valid && row.ready) begin
        if (expected_rows.size() == 0) begin
          $display("%0t: row for step %0d arrived with none expected",
                   $time, row.step_number);
          fail_count++;
        end else begin
          want = expected_rows.pop_front();
          check_field("step_number", {44'd0, want.step_number}, {44'd0, row.step_number});
          check_field("time_value", {16'd0, want.time_value}, {16'd0, row.time_value});
          check_field("prey_level", {32'd0, want.prey_level}, {32'd0, row.prey_level});
          check_field("predator_level", {32'd0, want.predator_level},
                      {32'd0, row.predator_level});
          check_field("prey_change", {23'd0, want.prey_change}, {23'd0, row.prey_change});
          check_field("predator_change", {23'd0, want.predator_change},
                      {23'd0, row.predator_change});
          check_field("last_row", {63'd0, want.last_row}, {63'd0, row.last_row});
        end
      end
      if (tick.valid && tick.ready) begin
        predict_tick(tick.restart);
      end
      rows_pending = expected_rows.size();
    end
  end

endmodule

@@ tb/predator_prey_euler_step_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// predator_prey_euler_step_tb: stimulus and verdict for the Euler stepper
// Drives register settings and ticks with random gaps and row stalls; a
// checker beside the block predicts every row and counts mismatches.
// ----------------------------------------------------------------------------
module predator_prey_euler_step_tb;
  import ppe_pkg::*;

  localparam int          STEP_BITS     = 20;
  localparam int          NUM_REGS      = 8;
  localparam int          CYCLE_LIMIT   = 4_000_000;
  // longest restart tick plus margin for a dropped tick in flight
  localparam int          SETTLE_CYCLES = 24;
  localparam int          RANDOM_TICKS  = 1000;
  localparam logic [31:0] Q16_ONE       = 32'h0001_0000;
  localparam logic [31:0] ALL_ONES      = 32'hFFFF_FFFF;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_PREY_START;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic [CFG_DATA_W-1:0] reg_plan [NUM_REGS];
  int                    fail_count;
  int                    rows_pending;
  int                    cycle_count = 0;
  int                    stall_left  = 0;
  bit                    stall_on    = 1'b0;

  ppe_tick_if tick ();
  ppe_row_if  row ();

  predator_prey_euler_step #(
    .STEP_BITS(STEP_BITS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick),
    .row       (row)
  );

  ppe_row_checker #(
    .STEP_BITS(STEP_BITS)
  ) i_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .tick         (tick),
    .row          (row),
    .fail_count   (fail_count),
    .rows_pending (rows_pending)
  );

  always #5 clk = ~clk;

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Row receiver: mostly short stalls, now and then a long one; hold ready
  // high whenever stalls are switched off.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      row.ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_on && $urandom_range(0, 7) == 0) begin
      row.ready  <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                : $urandom_range(0, 3);
    end else begin
      row.ready <= 1'b1;
    end
  end

  // Present one tick and hold it until the block takes it. Valid stays high
  // on return so that back-to-back ticks need no extra edge.
  task automatic send_tick(input logic restart_flag);
    tick.valid   <= 1'b1;
    tick.restart <= restart_flag;
    do @(posedge clk); while (!tick.ready);
  endtask

  // Drop valid for a random gap: usually none, sometimes a few cycles,
  // rarely a long pause.
  task automatic idle_gap();
    int pick;
    int gap;
    pick = $urandom_range(0, 19);
    if (pick < 10) begin
      gap = 0;
    end else if (pick < 18) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 40);
    end
    if (gap != 0) begin
      tick.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off the sender until every predicted row has come back, then let a
  // dropped tick that may still be in flight run out.
  task automatic settle();
    tick.valid <= 1'b0;
    do @(posedge clk); while (rows_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all eight registers back to back once the block is quiet.
  task automatic configure(input logic [31:0] prey0, input logic [31:0] pred0,
                           input logic [31:0] growth, input logic [31:0] death,
                           input logic [31:0] feeds, input logic [31:0] eats,
                           input logic [31:0] dt, input logic [31:0] run_len);
    settle();
    reg_plan[REG_PREY_START]          = prey0;
    reg_plan[REG_PREDATOR_START]      = pred0;
    reg_plan[REG_PREY_GROWTH]         = growth;
    reg_plan[REG_PREDATOR_DEATH]      = death;
    reg_plan[REG_PREY_FEEDS_PREDATOR] = feeds;
    reg_plan[REG_PREDATOR_EATS_PREY]  = eats;
    reg_plan[REG_TIME_STEP]           = dt;
    reg_plan[REG_RUN_LENGTH]          = run_len;
    for (int i = 0; i <= int'(REG_RUN_LENGTH); i++) begin
      cfg_write <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= reg_plan[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  // Populations: mostly a few hundred units with a random fraction, plus
  // zero, full scale and raw random words.
  function automatic logic [31:0] rand_pop();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return ALL_ONES;
    if (pick < 4) return $urandom;
    return ($urandom_range(1, 400) << 16) | $urandom_range(0, 65535);
  endfunction

  // Rates: mostly between 0 and 2.0 in Q4.28.
  function automatic logic [31:0] rand_rate();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return ALL_ONES;
    if (pick == 2) return $urandom;
    return $urandom_range(0, 32'h2000_0000);
  endfunction

  // Step size: mostly small, with zero and the largest value now and then.
  function automatic logic [31:0] rand_dt();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return ALL_ONES;
    if (pick == 1) return $urandom;
    if (pick == 2) return '0;
    return $urandom_range(32'h0010_0000, 32'h0400_0000);
  endfunction

  // Run length: short runs mostly; zero, the step cap, beyond the cap and
  // junk above the register width.
  function automatic logic [31:0] rand_run_length();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick == 1) return ALL_ONES;
    if (pick == 2) return 32'h0010_0000 + $urandom_range(0, 1);
    if (pick == 3) return ($urandom & 32'hFFE0_0000) | $urandom_range(1, 40);
    return $urandom_range(1, 40);
  endfunction

  initial begin
    int ticks_sent;
    int n_ticks;
    bit burst;
    bit restart;

    tick.valid   = 1'b0;
    tick.restart = 1'b0;
    row.ready    = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    stall_on = 1'b1;

    // Reset registers: an advance with no run is dropped, a restart gives a
    // single all-zero row marked last, the advance after it is dropped.
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);

    // Textbook populations and rates, four steps of 0.01, then one tick past
    // the end of the run.
    configure(10 * Q16_ONE, 5 * Q16_ONE, 32'h1199_999A, 32'h0666_6666,
              32'h0199_999A, 32'h0666_6666, 32'h0028_F5C3, 32'd4);
    send_tick(1'b1);
    repeat (4) begin
      send_tick(1'b0);
      idle_gap();
    end

    // Rewrite registers mid-run: the run is already past the new length so
    // the next step ends it, with the new step size in its time but the old
    // rates. Only the restart after that picks up the new rates.
    configure(10 * Q16_ONE, 5 * Q16_ONE, 32'h1199_999A, 32'h0666_6666,
              32'h0199_999A, 32'h0666_6666, 32'h0028_F5C3, 32'd10);
    send_tick(1'b1);
    repeat (4) send_tick(1'b0);
    configure(3 * Q16_ONE, 2 * Q16_ONE, 32'h0800_0000, 32'h0400_0000,
              32'h0200_0000, 32'h0100_0000, 32'h0100_0000, 32'd3);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);

    // Everything at full scale with run length zero: scaled rates saturate,
    // prey goes negative and clamps, predators overflow and both changes
    // saturate; the one row is last.
    configure(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
              32'd0);
    send_tick(1'b1);

    // Prey saturates at the top with no predators; run length beyond the cap.
    configure(ALL_ONES, 32'd0, ALL_ONES, 32'd0, 32'd0, 32'd0, 32'h1000_0000, ALL_ONES);
    send_tick(1'b1);
    send_tick(1'b0);

    // Random phases: fresh registers each time, a run that usually starts
    // with a restart, occasional restarts inside, and ticks that may fall
    // past the end of the run. Skipping the opening restart exercises writes
    // in the middle of a run.
    ticks_sent = 0;
    while (ticks_sent < RANDOM_TICKS) begin
      configure(rand_pop(), rand_pop(), rand_rate(), rand_rate(), rand_rate(),
                rand_rate(), rand_dt(), rand_run_length());
      stall_on = ($urandom_range(0, 3) != 0);
      burst    = ($urandom_range(0, 3) == 0);
      n_ticks  = $urandom_range(4, 60);
      for (int k = 0; k < n_ticks; k++) begin
        if (k == 0) begin
          restart = ($urandom_range(0, 9) < 7);
        end else begin
          restart = ($urandom_range(0, 15) == 0);
        end
        send_tick(restart);
        ticks_sent++;
        if (!burst) begin
          idle_gap();
        end
      end
    end

    // Drain the remaining rows, then give the block time to show any extra.
    tick.valid <= 1'b0;
    do @(posedge clk); while (rows_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && rows_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
